/* rtl/scrtmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrtmp_pkg
// Shared types, constants and the byte-wide CRC-8 update for the scratchpad
// CRC and temperature checker.
// ----------------------------------------------------------------------------
package scrtmp_pkg;

   localparam int DataWidth    = 8;
   localparam int TempWidth    = 16;
   localparam int PosWidth     = 4;
   localparam int CrcBytes     = 8;
   localparam int FrameBytes   = 9;
   localparam logic [7:0] CrcPolyReflected = 8'h8C;

   localparam logic [PosWidth-1:0] PosTempLow  = PosWidth'(0);
   localparam logic [PosWidth-1:0] PosTempHigh = PosWidth'(1);
   localparam logic [PosWidth-1:0] PosCheck    = PosWidth'(CrcBytes);
   localparam logic [PosWidth-1:0] PosIdle     = PosWidth'(FrameBytes);

   typedef struct packed {
      logic                 frame_start;
      logic [DataWidth-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic                        crc_ok;
      logic signed [TempWidth-1:0] temperature_sixteenths;
   } result_type;

   // Reflected 1-Wire CRC-8, one byte, LSB first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                              input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPolyReflected;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/scrtmp_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrtmp_in_stage
// Input register: captures one request transaction and holds it until the
// result side can take the work.
// ----------------------------------------------------------------------------
module scrtmp_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  scrtmp_pkg::item_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output scrtmp_pkg::item_type item
);

   logic                 valid_ff;
   logic                 valid_in;
   scrtmp_pkg::item_type item_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/scrtmp_frame.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrtmp_frame
// Frame tracker: byte count, running CRC and kept temperature bytes; decides
// the result on the ninth byte of a frame.
// ----------------------------------------------------------------------------
module scrtmp_frame (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  scrtmp_pkg::item_type   item,
   output logic                   res_valid,
   output scrtmp_pkg::result_type res
);

   logic [7:0]                          running_crc_ff, running_crc_in;
   logic [scrtmp_pkg::PosWidth-1:0]     byte_position_ff, byte_position_in;
   logic [7:0]                          temp_low_byte_ff, temp_low_byte_in;
   logic [7:0]                          temp_high_byte_ff, temp_high_byte_in;
   logic [7:0]                          crc_cur;
   logic [scrtmp_pkg::PosWidth-1:0]     pos;
   logic                                ok;

   assign crc_cur = item.frame_start ? 8'h00 : running_crc_ff;
   assign pos     = item.frame_start ? scrtmp_pkg::PosTempLow : byte_position_ff;
   assign ok      = (crc_cur == item.data_byte);

   always_comb begin
      running_crc_in    = running_crc_ff;
      byte_position_in  = byte_position_ff;
      temp_low_byte_in  = temp_low_byte_ff;
      temp_high_byte_in = temp_high_byte_ff;
      res_valid         = 1'b0;
      res.crc_ok                 = ok;
      res.temperature_sixteenths = ok ? {temp_high_byte_ff, temp_low_byte_ff}
                                      : '0;
      if (fire) begin
         if (pos < scrtmp_pkg::PosCheck) begin
            if (pos == scrtmp_pkg::PosTempLow) begin
               temp_low_byte_in = item.data_byte;
            end
            if (pos == scrtmp_pkg::PosTempHigh) begin
               temp_high_byte_in = item.data_byte;
            end
            running_crc_in   = scrtmp_pkg::crc8_update(crc_cur, item.data_byte);
            byte_position_in = pos + 1'b1;
         end else if (pos == scrtmp_pkg::PosCheck) begin
            res_valid        = 1'b1;
            running_crc_in   = crc_cur;
            byte_position_in = scrtmp_pkg::PosIdle;
         end else begin
            running_crc_in   = crc_cur;
            byte_position_in = pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff    <= '0;
         byte_position_ff  <= '0;
         temp_low_byte_ff  <= '0;
         temp_high_byte_ff <= '0;
      end else begin
         running_crc_ff    <= running_crc_in;
         byte_position_ff  <= byte_position_in;
         temp_low_byte_ff  <= temp_low_byte_in;
         temp_high_byte_ff <= temp_high_byte_in;
      end
   end

`ifndef SYNTHESIS
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      byte_position_ff <= scrtmp_pkg::PosIdle)
      else $error("byte position out of range");

   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> byte_position_ff == scrtmp_pkg::PosIdle)
      else $error("frame not closed after result");

   a_bad_crc_zero_temp: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.crc_ok |-> res.temperature_sixteenths == '0)
      else $error("temperature given on crc mismatch");

   a_start_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && item.frame_start |=> byte_position_ff == scrtmp_pkg::PosTempHigh)
      else $error("frame start did not restart count");
`endif

endmodule

/* rtl/scrtmp_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrtmp_out_stage
// Result register: holds a result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module scrtmp_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   res_valid,
   input  scrtmp_pkg::result_type res,
   output logic                   load_ok,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output scrtmp_pkg::result_type rsp_result
);

   logic                   valid_ff;
   logic                   valid_in;
   scrtmp_pkg::result_type result_ff;

   assign load_ok  = !valid_ff || rsp_tready;
   assign valid_in = load_ok ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok && res_valid) begin
         result_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = result_ff;

endmodule

/* rtl/scrtmp_core_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scratchpad_crc_temperature_core
// Checks nine-byte sensor scratchpad frames: CRC-8 over bytes 0..7 against
// byte 8, and returns the raw temperature in sixteenths of a degree.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle unless the result consumer stalls. Each frame of
// nine bytes yields one result transaction; bytes 0..7 yield nothing. The CRC
// update of one byte is the longest path, between the input register and the
// frame state. A result waiting in the output register does not stop input:
// the input register parts the two sides and only fills up when the result
// consumer stalls. On a CRC mismatch the temperature is 0.
// ----------------------------------------------------------------------------
module scratchpad_crc_temperature_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] temperature_sixteenths
   output logic        rsp_tuser    // [0] crc_ok
);

   scrtmp_pkg::item_type   req_item;
   scrtmp_pkg::item_type   item;
   scrtmp_pkg::result_type res;
   scrtmp_pkg::result_type rsp_result;
   logic                   item_valid;
   logic                   load_ok;
   logic                   res_valid;

   assign req_item.data_byte   = req_tdata;
   assign req_item.frame_start = req_tuser;

   scrtmp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (load_ok),
      .item_valid (item_valid),
      .item       (item)
   );

   scrtmp_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .fire      (item_valid && load_ok),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   scrtmp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = rsp_result.temperature_sixteenths;
   assign rsp_tuser = rsp_result.crc_ok;

endmodule
